### design/qkm_pkg.sv
// Shared types, constants and lookup functions for the quadrilateral keypoint metrics block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package qkm_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 12;
    localparam int CORDIC_STAGES_DEF   = 14;
    localparam int ATAN_TAB_LEN        = 24;
    localparam int ACC_BITS            = 30;
    localparam int ANG_W               = 36;
    localparam int CORD_W              = 40;
    localparam int LEN_W               = 33;
    localparam int DIV_STEPS           = 32;
    localparam int SQRT_STEPS          = 16;
    localparam int ASP_LAT             = 3 + DIV_STEPS + SQRT_STEPS;
    localparam int LATENCY             = 1 + ASP_LAT + 2;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;

    typedef struct packed {
        logic signed [15:0] tl_x;
        logic signed [15:0] tl_y;
        logic signed [15:0] tr_x;
        logic signed [15:0] tr_y;
        logic signed [15:0] br_x;
        logic signed [15:0] br_y;
        logic signed [15:0] bl_x;
        logic signed [15:0] bl_y;
        logic signed [15:0] shift_x;
        logic signed [15:0] shift_y;
    } qkm_req_t;

    typedef struct packed {
        logic signed [15:0] out_tl_x;
        logic signed [15:0] out_tl_y;
        logic signed [15:0] out_tr_x;
        logic signed [15:0] out_tr_y;
        logic signed [15:0] out_br_x;
        logic signed [15:0] out_br_y;
        logic signed [15:0] out_bl_x;
        logic signed [15:0] out_bl_y;
        logic signed [15:0] mid_x;
        logic signed [15:0] mid_y;
        logic        [15:0] aspect;
        logic        [15:0] skew_error;
    } qkm_res_t;

    typedef struct packed {
        logic signed [15:0] tl_x;
        logic signed [15:0] tl_y;
        logic signed [15:0] tr_x;
        logic signed [15:0] tr_y;
        logic signed [15:0] br_x;
        logic signed [15:0] br_y;
        logic signed [15:0] bl_x;
        logic signed [15:0] bl_y;
    } qkm_pts_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] roll;
        logic signed [ANG_W-1:0] left;
        logic signed [ANG_W-1:0] right;
    } qkm_ang_t;

    function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
        case (idx)
            0:       return 36'sd843314857;
            1:       return 36'sd497837829;
            2:       return 36'sd263043837;
            3:       return 36'sd133525159;
            4:       return 36'sd67021687;
            5:       return 36'sd33543516;
            6:       return 36'sd16775851;
            7:       return 36'sd8388437;
            8:       return 36'sd4194283;
            9:       return 36'sd2097149;
            10:      return 36'sd1048576;
            11:      return 36'sd524288;
            12:      return 36'sd262144;
            13:      return 36'sd131072;
            14:      return 36'sd65536;
            15:      return 36'sd32768;
            16:      return 36'sd16384;
            17:      return 36'sd8192;
            18:      return 36'sd4096;
            19:      return 36'sd2048;
            20:      return 36'sd1024;
            21:      return 36'sd512;
            22:      return 36'sd256;
            23:      return 36'sd128;
            default: return '0;
        endcase
    endfunction

endpackage

`default_nettype wire

### design/quad_keypoint_metrics_top.sv
// A request is registered with its shift applied, passes the lanes and the merging stage, and done marks its result.
// Throughput: one request per cycle; busy is always low and results cannot be stalled.
// The aspect lane sets the depth of the pipeline: 32 divider stages and 16 square-root stages.
// Reset clears only the valid pipeline, so no result strobe follows reset by itself.
// Top level of the quadrilateral keypoint metrics block; depends on qkm_pkg and all lanes.
`default_nettype none

module quad_keypoint_metrics_top
    import qkm_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire qkm_req_t request,
    output logic          done,
    output qkm_res_t      result
);

    qkm_pts_t           pts_reg;
    logic [LATENCY-1:0] vld_reg;
    logic [LATENCY-1:0] vld_next;
    qkm_ang_t           ang;
    logic [15:0]        aspect;

    function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
        logic signed [16:0] s;
        s = 17'(a) + 17'(b);
        if (s > 17'sd32767)
            return 16'sh7FFF;
        else if (s < -17'sd32768)
            return 16'sh8000;
        else
            return s[15:0];
    endfunction

    assign busy     = 1'b0;
    assign vld_next = {vld_reg[LATENCY-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        pts_reg.tl_x <= sat_add(request.tl_x, request.shift_x);
        pts_reg.tl_y <= sat_add(request.tl_y, request.shift_y);
        pts_reg.tr_x <= sat_add(request.tr_x, request.shift_x);
        pts_reg.tr_y <= sat_add(request.tr_y, request.shift_y);
        pts_reg.br_x <= sat_add(request.br_x, request.shift_x);
        pts_reg.br_y <= sat_add(request.br_y, request.shift_y);
        pts_reg.bl_x <= sat_add(request.bl_x, request.shift_x);
        pts_reg.bl_y <= sat_add(request.bl_y, request.shift_y);
    end

    qkm_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
        .clk   (clk),
        .vec_x (18'(pts_reg.tr_x) + 18'(pts_reg.br_x) - 18'(pts_reg.tl_x) - 18'(pts_reg.bl_x)),
        .vec_y (18'(pts_reg.tr_y) + 18'(pts_reg.br_y) - 18'(pts_reg.tl_y) - 18'(pts_reg.bl_y)),
        .angle (ang.roll)
    );

    qkm_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_left (
        .clk   (clk),
        .vec_x (18'(pts_reg.bl_x) - 18'(pts_reg.tl_x)),
        .vec_y (18'(pts_reg.bl_y) - 18'(pts_reg.tl_y)),
        .angle (ang.left)
    );

    qkm_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_right (
        .clk   (clk),
        .vec_x (18'(pts_reg.br_x) - 18'(pts_reg.tr_x)),
        .vec_y (18'(pts_reg.br_y) - 18'(pts_reg.tr_y)),
        .angle (ang.right)
    );

    qkm_aspect u_aspect (
        .clk    (clk),
        .pts    (pts_reg),
        .aspect (aspect)
    );

    qkm_merge #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STAGES   (CORDIC_STAGES)
    ) u_merge (
        .clk    (clk),
        .pts    (pts_reg),
        .ang    (ang),
        .aspect (aspect),
        .res    (result)
    );

    assign done = vld_reg[LATENCY-1];

endmodule

`default_nettype wire

### design/qkm_cordic.sv
// One angle lane: pipelined vectoring CORDIC, one micro-rotation per stage.
// Depends on qkm_pkg for widths, pi and the arctangent table.
`default_nettype none

module qkm_cordic
    import qkm_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  wire logic                    clk,
    input  wire logic signed [17:0]      vec_x,
    input  wire logic signed [17:0]      vec_y,
    output logic signed [ANG_W-1:0]      angle
);

    logic signed [CORD_W-1:0] x_reg [0:CORDIC_STAGES];
    logic signed [CORD_W-1:0] y_reg [0:CORDIC_STAGES];
    logic signed [ANG_W-1:0]  z_reg [0:CORDIC_STAGES];
    logic                     zero_reg [0:CORDIC_STAGES];

    logic signed [18:0]       ax_next;
    logic signed [18:0]       ay_next;
    logic signed [ANG_W-1:0]  z_next;

    always_comb
    begin
        if (vec_x < 0)
        begin
            ax_next = -19'(vec_x);
            ay_next = -19'(vec_y);
            z_next  = (vec_y >= 0) ? PI_Q30 : -PI_Q30;
        end
        else
        begin
            ax_next = 19'(vec_x);
            ay_next = 19'(vec_y);
            z_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= CORD_W'(ax_next) <<< 16;
        y_reg[0]    <= CORD_W'(ay_next) <<< 16;
        z_reg[0]    <= z_next;
        zero_reg[0] <= (vec_x == 0) && (vec_y == 0);
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (!y_reg[i][CORD_W-1])
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + atan_q30(i);
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - atan_q30(i);
            end
            zero_reg[i+1] <= zero_reg[i];
        end
    end

    assign angle = zero_reg[CORDIC_STAGES] ? '0 : z_reg[CORDIC_STAGES];

endmodule

`default_nettype wire

### design/qkm_aspect.sv
// Aspect lane: squared edge lengths, pipelined restoring divider and square root.
// Depends on qkm_pkg for the point type and stage counts.
`default_nettype none

module qkm_aspect
    import qkm_pkg::*;
(
    input  wire logic        clk,
    input  wire qkm_pts_t    pts,
    output logic [15:0]      aspect
);

    logic [31:0]        sq_reg [0:7];
    logic [LEN_W-1:0]   l2_reg;
    logic [LEN_W-1:0]   w2_reg;

    logic [LEN_W-1:0]   drem_reg [0:DIV_STEPS];
    logic [LEN_W-1:0]   dden_reg [0:DIV_STEPS];
    logic [31:0]        dnum_reg [0:DIV_STEPS-1];
    logic [31:0]        dquo_reg [0:DIV_STEPS];
    logic               dsat_reg [0:DIV_STEPS];

    logic [31:0]        sval_reg  [0:SQRT_STEPS-1];
    logic [17:0]        srem_reg  [0:SQRT_STEPS-1];
    logic [15:0]        sroot_reg [0:SQRT_STEPS-1];
    logic               ssat_reg  [0:SQRT_STEPS-1];

    logic [LEN_W-1:0]   top_len;
    logic [LEN_W-1:0]   bot_len;
    logic [LEN_W-1:0]   lft_len;
    logic [LEN_W-1:0]   rgt_len;

    function automatic logic [31:0] sq_diff(input logic signed [15:0] a,
                                            input logic signed [15:0] b);
        logic signed [16:0] d;
        logic signed [33:0] p;
        d = 17'(a) - 17'(b);
        p = d * d;
        return p[31:0];
    endfunction

    always_ff @(posedge clk)
    begin
        sq_reg[0] <= sq_diff(pts.tl_x, pts.tr_x);
        sq_reg[1] <= sq_diff(pts.tl_y, pts.tr_y);
        sq_reg[2] <= sq_diff(pts.bl_x, pts.br_x);
        sq_reg[3] <= sq_diff(pts.bl_y, pts.br_y);
        sq_reg[4] <= sq_diff(pts.tl_x, pts.bl_x);
        sq_reg[5] <= sq_diff(pts.tl_y, pts.bl_y);
        sq_reg[6] <= sq_diff(pts.tr_x, pts.br_x);
        sq_reg[7] <= sq_diff(pts.tr_y, pts.br_y);
    end

    assign top_len = LEN_W'(sq_reg[0]) + LEN_W'(sq_reg[1]);
    assign bot_len = LEN_W'(sq_reg[2]) + LEN_W'(sq_reg[3]);
    assign lft_len = LEN_W'(sq_reg[4]) + LEN_W'(sq_reg[5]);
    assign rgt_len = LEN_W'(sq_reg[6]) + LEN_W'(sq_reg[7]);

    always_ff @(posedge clk)
    begin
        l2_reg <= (top_len > bot_len) ? top_len : bot_len;
        w2_reg <= (lft_len > rgt_len) ? lft_len : rgt_len;
    end

    always_ff @(posedge clk)
    begin
        drem_reg[0] <= LEN_W'(l2_reg[LEN_W-1:16]);
        dden_reg[0] <= w2_reg;
        dnum_reg[0] <= {l2_reg[15:0], 16'h0000};
        dquo_reg[0] <= '0;
        dsat_reg[0] <= (w2_reg == '0) || (LEN_W'(l2_reg[LEN_W-1:16]) >= w2_reg);
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        logic [LEN_W:0] t;
        assign t = {drem_reg[k], dnum_reg[k][31]};
        always_ff @(posedge clk)
        begin
            if (t >= {1'b0, dden_reg[k]})
            begin
                drem_reg[k+1] <= LEN_W'(t - {1'b0, dden_reg[k]});
                dquo_reg[k+1] <= {dquo_reg[k][30:0], 1'b1};
            end
            else
            begin
                drem_reg[k+1] <= LEN_W'(t);
                dquo_reg[k+1] <= {dquo_reg[k][30:0], 1'b0};
            end
            dden_reg[k+1] <= dden_reg[k];
            dsat_reg[k+1] <= dsat_reg[k];
        end
        if (k < DIV_STEPS - 1)
        begin : g_num
            always_ff @(posedge clk)
            begin
                dnum_reg[k+1] <= {dnum_reg[k][30:0], 1'b0};
            end
        end
    end

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        logic [31:0] v_in;
        logic [17:0] r_in;
        logic [15:0] q_in;
        logic        s_in;
        logic [19:0] t;
        logic [19:0] trial;
        if (j == 0)
        begin : g_first
            assign v_in = dquo_reg[DIV_STEPS];
            assign r_in = '0;
            assign q_in = '0;
            assign s_in = dsat_reg[DIV_STEPS];
        end
        else
        begin : g_next
            assign v_in = sval_reg[j-1];
            assign r_in = srem_reg[j-1];
            assign q_in = sroot_reg[j-1];
            assign s_in = ssat_reg[j-1];
        end
        assign t     = {r_in, v_in[31:30]};
        assign trial = {2'b00, q_in, 2'b01};
        always_ff @(posedge clk)
        begin
            if (t >= trial)
            begin
                srem_reg[j]  <= 18'(t - trial);
                sroot_reg[j] <= {q_in[14:0], 1'b1};
            end
            else
            begin
                srem_reg[j]  <= 18'(t);
                sroot_reg[j] <= {q_in[14:0], 1'b0};
            end
            sval_reg[j] <= {v_in[29:0], 2'b00};
            ssat_reg[j] <= s_in;
        end
    end

    assign aspect = ssat_reg[SQRT_STEPS-1] ? 16'hFFFF : sroot_reg[SQRT_STEPS-1];

endmodule

`default_nettype wire

### design/qkm_merge.sv
// Merging stage: aligns the angle lanes with the aspect lane and forms the result.
// Depends on qkm_pkg for the point, angle and result types.
`default_nettype none

module qkm_merge
    import qkm_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
)
(
    input  wire logic        clk,
    input  wire qkm_pts_t    pts,
    input  wire qkm_ang_t    ang,
    input  wire logic [15:0] aspect,
    output qkm_res_t         res
);

    localparam int ANG_DLY = ASP_LAT - 1 - CORDIC_STAGES;
    localparam int SH      = ACC_BITS - ANGLE_FRAC_BITS;

    qkm_ang_t                 ang_dly_reg [0:ANG_DLY-1];
    qkm_pts_t                 pts_dly_reg [0:ASP_LAT-1];
    logic signed [ANG_W-1:0]  el_reg;
    logic signed [ANG_W-1:0]  er_reg;
    logic [15:0]              asp_reg;
    qkm_pts_t                 pts_reg;
    qkm_res_t                 res_reg;

    logic [ANG_W-1:0]         ael;
    logic [ANG_W-1:0]         aer;
    logic [ANG_W:0]           rnd;
    logic [ANG_W:0]           skew;
    logic signed [17:0]       sum_x;
    logic signed [17:0]       sum_y;

    always_ff @(posedge clk)
    begin
        ang_dly_reg[0] <= ang;
        pts_dly_reg[0] <= pts;
    end

    for (genvar i = 1; i < ANG_DLY; i++)
    begin : g_ang_dly
        always_ff @(posedge clk)
        begin
            ang_dly_reg[i] <= ang_dly_reg[i-1];
        end
    end

    for (genvar i = 1; i < ASP_LAT; i++)
    begin : g_pts_dly
        always_ff @(posedge clk)
        begin
            pts_dly_reg[i] <= pts_dly_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        el_reg  <= ang_dly_reg[ANG_DLY-1].left - ang_dly_reg[ANG_DLY-1].roll - HALF_PI_Q30;
        er_reg  <= ang_dly_reg[ANG_DLY-1].right - ang_dly_reg[ANG_DLY-1].roll - HALF_PI_Q30;
        asp_reg <= aspect;
        pts_reg <= pts_dly_reg[ASP_LAT-1];
    end

    always_comb
    begin
        ael   = el_reg[ANG_W-1] ? ANG_W'(-el_reg) : ANG_W'(el_reg);
        aer   = er_reg[ANG_W-1] ? ANG_W'(-er_reg) : ANG_W'(er_reg);
        rnd   = ((ael > aer) ? {1'b0, ael} : {1'b0, aer}) + ((ANG_W+1)'(1) << (SH - 1));
        skew  = rnd >> SH;
        sum_x = 18'(pts_reg.tl_x) + 18'(pts_reg.tr_x) + 18'(pts_reg.br_x)
              + 18'(pts_reg.bl_x) + 18'sd2;
        sum_y = 18'(pts_reg.tl_y) + 18'(pts_reg.tr_y) + 18'(pts_reg.br_y)
              + 18'(pts_reg.bl_y) + 18'sd2;
    end

    always_ff @(posedge clk)
    begin
        res_reg.out_tl_x   <= pts_reg.tl_x;
        res_reg.out_tl_y   <= pts_reg.tl_y;
        res_reg.out_tr_x   <= pts_reg.tr_x;
        res_reg.out_tr_y   <= pts_reg.tr_y;
        res_reg.out_br_x   <= pts_reg.br_x;
        res_reg.out_br_y   <= pts_reg.br_y;
        res_reg.out_bl_x   <= pts_reg.bl_x;
        res_reg.out_bl_y   <= pts_reg.bl_y;
        res_reg.mid_x      <= sum_x[17:2];
        res_reg.mid_y      <= sum_y[17:2];
        res_reg.aspect     <= asp_reg;
        res_reg.skew_error <= (skew > (ANG_W+1)'(16'hFFFF)) ? 16'hFFFF : skew[15:0];
    end

    assign res = res_reg;

endmodule

`default_nettype wire

### design/qkm_checker.sv
// Port-level checker for the quadrilateral keypoint metrics block, bound to the top level.
// Depends on qkm_pkg for the request and result types and the fixed latency.
`default_nettype none

module qkm_checker
    import qkm_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire qkm_req_t request,
    input wire logic     done,
    input wire qkm_res_t result
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised although the block accepts every cycle");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted request produced no result at the fixed latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LATENCY !done)
        else $error("result strobe without a matching request");

    a_mid_x_hull: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.mid_x > result.out_tl_x && result.mid_x > result.out_tr_x &&
                   result.mid_x > result.out_br_x && result.mid_x > result.out_bl_x))
        else $error("center x lies beyond all corners");

    a_mid_y_hull: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.mid_y < result.out_tl_y && result.mid_y < result.out_tr_y &&
                   result.mid_y < result.out_br_y && result.mid_y < result.out_bl_y))
        else $error("center y lies below all corners");

endmodule

bind quad_keypoint_metrics_top qkm_checker u_qkm_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);

`default_nettype wire
